@@ hw/rtl/ctts_pkg.sv @@
// Shared constants and types for the tick scheduler.
`timescale 1ns / 1ps
`default_nettype none

package ctts_pkg;

    localparam int TASK_SLOTS = 8;
    localparam int SLOT_W     = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int CNT_W      = $clog2(TASK_SLOTS + 1);
    localparam int MAX_RUNS   = 8;
    localparam int RUN_W      = $clog2(MAX_RUNS + 1);

    localparam int OP_W       = 2;
    localparam int ID_W       = 3;
    localparam int TIME_W     = 16;
    localparam int KIND_W     = 2;
    localparam int RUNSLOT_W  = 3;
    localparam int COUNT_W    = 4;

    typedef enum logic [OP_W-1:0] {
        OP_TICK,
        OP_ADD,
        OP_DEL,
        OP_DISPATCH
    } t_op;

    typedef enum logic [KIND_W-1:0] {
        KIND_RUN,
        KIND_ADD_DONE,
        KIND_DEL_DONE,
        KIND_DISP_DONE
    } t_kind;

    typedef struct packed {
        logic              ready;
        logic [TIME_W-1:0] delay;
        logic [TIME_W-1:0] period;
    } t_slot;

endpackage

`default_nettype wire

@@ hw/rtl/ctts_if.sv @@
// Handshake channels for scheduler commands and results.
`timescale 1ns / 1ps
`default_nettype none

interface ctts_in_if;
    logic                         valid;
    logic                         ready;
    logic [ctts_pkg::OP_W-1:0]    op;
    logic [ctts_pkg::ID_W-1:0]    slot_id;
    logic [ctts_pkg::TIME_W-1:0]  first_delay;
    logic [ctts_pkg::TIME_W-1:0]  repeat_period;

    modport source (output valid, op, slot_id, first_delay, repeat_period, input ready);
    modport sink   (input valid, op, slot_id, first_delay, repeat_period, output ready);
endinterface

interface ctts_out_if;
    logic                            valid;
    logic                            ready;
    logic [ctts_pkg::KIND_W-1:0]     kind;
    logic [ctts_pkg::RUNSLOT_W-1:0]  run_slot;
    logic [ctts_pkg::COUNT_W-1:0]    task_count;
    logic                            last;

    modport source (output valid, kind, run_slot, task_count, last, input ready);
    modport sink   (input valid, kind, run_slot, task_count, last, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/ctts_slot_mem.sv @@
// Task slot table: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module ctts_slot_mem (
    input  wire logic                          i_clk,
    input  wire logic                          i_we,
    input  wire logic [ctts_pkg::SLOT_W-1:0]   i_waddr,
    input  wire ctts_pkg::t_slot               i_wdata,
    input  wire logic                          i_re,
    input  wire logic [ctts_pkg::SLOT_W-1:0]   i_raddr,
    output ctts_pkg::t_slot                    o_rdata
);

    ctts_pkg::t_slot r_mem [ctts_pkg::TASK_SLOTS];
    ctts_pkg::t_slot r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds while the walk is stalled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ hw/rtl/cooperative_task_tick_scheduler.sv @@
// Top level of the time-triggered cooperative tick scheduler.
//
// Commands arrive on i_in (op, slot_id, first_delay, repeat_period); results
// leave on o_out (kind, run_slot, task_count, last). Both are valid/ready.
// Add (when the table is not full) and delete update the table on the
// accepting beat; each returns one result beat through the done state and
// the output register. Tick and dispatch walk the slot table in the slot
// memory, one slot per cycle while the output is not stalled, with read and
// write-back overlapped: a tick gives no result; a dispatch gives one run
// beat per ready slot (at most 8) and then a finish beat with last set.
// A new command is taken only when the previous one is fully handed to the
// output register, so a final result may still wait there while the next
// command is accepted. When the receiver stalls, the walk holds on the slot
// that needs to emit. Reset clears the valid marks and the fill count; slot
// contents behind a cleared valid mark are never looked at, so the memory
// needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module cooperative_task_tick_scheduler (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    ctts_in_if.sink     i_in,
    ctts_out_if.source  o_out
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DONE
    } t_state;

    localparam int SLOT_W  = ctts_pkg::SLOT_W;
    localparam int CNT_W   = ctts_pkg::CNT_W;
    localparam int RUN_W   = ctts_pkg::RUN_W;
    localparam int COUNT_W = ctts_pkg::COUNT_W;

    t_state                         r_state;
    logic [ctts_pkg::TASK_SLOTS-1:0] r_valid;
    logic [CNT_W-1:0]               r_used;
    ctts_pkg::t_op                  r_op;
    logic [CNT_W-1:0]               r_idx;
    logic                           r_pv;
    logic [SLOT_W-1:0]              r_pidx;
    logic [RUN_W-1:0]               r_nrun;
    ctts_pkg::t_kind                r_done_kind;
    logic [COUNT_W-1:0]             r_done_count;

    logic                           r_out_valid;
    ctts_pkg::t_kind                r_out_kind;
    logic [ctts_pkg::RUNSLOT_W-1:0] r_out_slot;
    logic [COUNT_W-1:0]             r_out_count;
    logic                           r_out_last;

    ctts_pkg::t_op   in_op;
    ctts_pkg::t_slot rd_slot;
    ctts_pkg::t_slot n_slot;
    logic            accept;
    logic            out_free;
    logic            out_load;
    logic            cur_valid;
    logic            want_run;
    logic            stall;
    logic            advance;
    logic            last_read;
    logic            table_full;
    logic            del_in_range;
    logic [SLOT_W-1:0] del_idx;
    logic            mem_we;
    logic [SLOT_W-1:0] mem_waddr;
    logic            mem_re;

    assign in_op        = ctts_pkg::t_op'(i_in.op);
    assign i_in.ready   = (r_state == S_IDLE);
    assign accept       = i_in.valid && i_in.ready;
    assign out_free     = !r_out_valid || o_out.ready;
    assign table_full   = (r_used >= CNT_W'(ctts_pkg::TASK_SLOTS));
    assign del_in_range = (32'(i_in.slot_id) < ctts_pkg::TASK_SLOTS);
    assign del_idx      = SLOT_W'(i_in.slot_id);

    assign cur_valid = r_valid[r_pidx];
    assign want_run  = (r_op == ctts_pkg::OP_DISPATCH) && cur_valid && rd_slot.ready
                       && (r_nrun < RUN_W'(ctts_pkg::MAX_RUNS));
    assign stall     = r_pv && want_run && !out_free;
    assign advance   = (r_state == S_WALK) && !stall;
    assign last_read = (r_idx == CNT_W'(ctts_pkg::TASK_SLOTS));
    assign mem_re    = advance && !last_read;
    assign out_load  = (advance && r_pv && want_run) || ((r_state == S_DONE) && out_free);

    // single write port: add in idle, write-back during a walk
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_pidx;
        n_slot    = rd_slot;
        priority if (accept && in_op == ctts_pkg::OP_ADD && !table_full) begin
            mem_we        = 1'b1;
            mem_waddr     = r_used[SLOT_W-1:0];
            n_slot.ready  = 1'b0;
            n_slot.delay  = i_in.first_delay;
            n_slot.period = i_in.repeat_period;
        end else if (advance && r_pv && cur_valid) begin
            if (r_op == ctts_pkg::OP_TICK) begin
                mem_we = 1'b1;
                if (rd_slot.delay == '0) begin
                    n_slot.ready = 1'b1;
                    if (rd_slot.period != '0) begin
                        n_slot.delay = rd_slot.period;
                    end
                end else begin
                    n_slot.delay = rd_slot.delay - 1'b1;
                end
            end else if (want_run) begin
                mem_we       = 1'b1;
                n_slot.ready = 1'b0;
            end
        end else begin
            mem_we = 1'b0;
        end
    end

    ctts_slot_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (n_slot),
        .i_re    (mem_re),
        .i_raddr (r_idx[SLOT_W-1:0]),
        .o_rdata (rd_slot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_used      <= '0;
            r_idx       <= '0;
            r_pv        <= 1'b0;
            r_nrun      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_op <= in_op;
                        unique case (in_op)
                            ctts_pkg::OP_TICK, ctts_pkg::OP_DISPATCH: begin
                                r_idx   <= '0;
                                r_pv    <= 1'b0;
                                r_nrun  <= '0;
                                r_state <= S_WALK;
                            end
                            ctts_pkg::OP_ADD: begin
                                r_done_kind <= ctts_pkg::KIND_ADD_DONE;
                                if (table_full) begin
                                    r_done_count <= COUNT_W'(r_used);
                                end else begin
                                    r_valid[r_used[SLOT_W-1:0]] <= 1'b1;
                                    r_used       <= r_used + 1'b1;
                                    r_done_count <= COUNT_W'(r_used + 1'b1);
                                end
                                r_state <= S_DONE;
                            end
                            ctts_pkg::OP_DEL: begin
                                if (del_in_range) begin
                                    r_valid[del_idx] <= 1'b0;
                                end
                                r_done_kind  <= ctts_pkg::KIND_DEL_DONE;
                                r_done_count <= '0;
                                r_state      <= S_DONE;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_WALK: begin
                    if (advance) begin
                        if (r_pv && want_run) begin
                            r_out_kind  <= ctts_pkg::KIND_RUN;
                            r_out_slot  <= ctts_pkg::RUNSLOT_W'(r_pidx);
                            r_out_count <= '0;
                            r_out_last  <= 1'b0;
                            r_nrun      <= r_nrun + 1'b1;
                            // one-shot task leaves the table once run
                            if (rd_slot.period == '0) begin
                                r_valid[r_pidx] <= 1'b0;
                            end
                        end
                        if (!last_read) begin
                            r_pv   <= 1'b1;
                            r_pidx <= r_idx[SLOT_W-1:0];
                            r_idx  <= r_idx + 1'b1;
                        end else begin
                            r_pv         <= 1'b0;
                            r_done_kind  <= ctts_pkg::KIND_DISP_DONE;
                            r_done_count <= '0;
                            r_state      <= (r_op == ctts_pkg::OP_DISPATCH) ? S_DONE : S_IDLE;
                        end
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_kind  <= r_done_kind;
                        r_out_slot  <= '0;
                        r_out_count <= r_done_count;
                        r_out_last  <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.kind       = r_out_kind;
    assign o_out.run_slot   = r_out_slot;
    assign o_out.task_count = r_out_count;
    assign o_out.last       = r_out_last;

endmodule

`default_nettype wire

@@ hw/rtl/ctts_checker.sv @@
// Port-level checks for the tick scheduler, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module ctts_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_in_ready,
    input wire logic                            i_out_valid,
    input wire logic                            i_out_ready,
    input wire logic [ctts_pkg::KIND_W-1:0]     i_out_kind,
    input wire logic [ctts_pkg::RUNSLOT_W-1:0]  i_out_run_slot,
    input wire logic [ctts_pkg::COUNT_W-1:0]    i_out_task_count,
    input wire logic                            i_out_last
);

    // a stalled result beat is not withdrawn
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped while stalled");

    // while a dispatch is still emitting, no new command is taken
    a_busy_mid_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_last |-> !i_in_ready)
        else $error("command accepted in the middle of a dispatch");

    a_run_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_kind == ctts_pkg::KIND_RUN
        |-> !i_out_last && i_out_task_count == '0)
        else $error("malformed run beat");

    a_add_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_kind == ctts_pkg::KIND_ADD_DONE
        |-> i_out_last && i_out_run_slot == '0
            && 32'(i_out_task_count) <= ctts_pkg::TASK_SLOTS)
        else $error("add result count beyond table size");

endmodule

bind cooperative_task_tick_scheduler ctts_checker u_ctts_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_ready       (i_in.ready),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_kind       (o_out.kind),
    .i_out_run_slot   (o_out.run_slot),
    .i_out_task_count (o_out.task_count),
    .i_out_last       (o_out.last)
);

`default_nettype wire
